FILE: sv/ssp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants of the sloped shadow projector
// Word layouts of the request and result channels and the fixed constants of
// the fade, slope scaling and opacity arithmetic.
// ----------------------------------------------------------------------------
package ssp_pkg;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] ground_y;
    logic signed [31:0] pos_z;
    logic        [14:0] shadow_size;
    logic signed [31:0] source_y;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic        [5:0]  slot;
    logic        [5:0]  fade_opacity;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [15:0] out_size;
    logic signed [15:0] corner_offset_a;
    logic signed [15:0] corner_offset_b;
    logic signed [15:0] corner_offset_c;
    logic        [5:0]  projection_opacity;
  } out_item_t;

  localparam logic REQ_QUEUE = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Divider operand widths: product magnitudes stay below 2**31.
  localparam int NUM_W = 31;
  localparam int DEN_W = 16;

  localparam int FADE_SHIFT = 10;
  localparam logic signed [32:0] FADE_ROUND = 33'sd1023;
  localparam logic signed [32:0] FADE_BIAS  = 33'sd64;
  localparam logic signed [32:0] FADE_TOP   = -33'sd32;
  localparam logic        [5:0]  FADE_MAX   = 6'd32;

  localparam logic signed [15:0] NY_STEEP = -16'sd4096;
  localparam logic signed [15:0] NY_SCALE = -16'sd12288;
  localparam logic signed [15:0] NY_FLAT  = -16'sd8192;
  localparam logic signed [16:0] SCALE_BIAS = -17'sd2048;
  localparam logic signed [16:0] POPAC_BIAS = -17'sd4096;
  localparam logic [DEN_W-1:0]   SCALE_DIV  = 16'h2800;
  localparam logic [5:0]         POPAC_FLAT = 6'd48;

endpackage

FILE: sv/ssp_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_chan_if: valid/ready channel
// Carries one word of type T from a source to a sink.
// ----------------------------------------------------------------------------
interface ssp_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/sloped_shadow_projector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sloped_shadow_projector: slope-aware shadow slot allocator
// Checks each shadow request, scales its size on steeper ground, projects the
// corner offsets through one shared divider and hands out the next slot; a clear request empties the slot count.
// ----------------------------------------------------------------------------
// A clear or a dropped request has its result word in the cycle after
// acceptance. A queued shadow takes three divisions, each a multiply state and
// a divider run, and then a finishing state; two divisions without size
// scaling. A new request is taken at the earliest in the cycle after the result
// word loads, so the shared divider works on one queued shadow at a time.
// Reset (synchronous, active high) empties the slot count and the pipeline.
// ----------------------------------------------------------------------------
module sloped_shadow_projector #(
  parameter int MAX_SLOTS = 64
) (
  input  logic clk,
  input  logic rst,
  ssp_chan_if.sink   req,
  ssp_chan_if.source rsp
);

  // Slot counter must be able to hold MAX_SLOTS itself.
  localparam int SW = $clog2(MAX_SLOTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // Which division is in flight.
  localparam logic [1:0] STEP_SCALE = 2'd0;
  localparam logic [1:0] STEP_SLOPE = 2'd1;
  localparam logic [1:0] STEP_QA    = 2'd2;

  logic [1:0]  state;
  logic [1:0]  step;
  logic [SW-1:0] slots_used;

  ssp_pkg::in_item_t  item;
  ssp_pkg::out_item_t out_word;
  logic               out_valid;

  logic [5:0]         fade;
  logic [14:0]        size_r;
  logic signed [31:0] slope;
  logic signed [31:0] qa;
  logic               div_neg;

  // Fade check, done on the request word as it arrives. The height difference
  // is exact in 33 bits; adding 1023 to a negative value makes the arithmetic
  // shift truncate toward zero.
  logic signed [32:0] diff;
  logic signed [32:0] diff_adj;
  logic signed [32:0] fq;
  logic               fade_neg;
  logic [5:0]         fade_val;
  logic               drop;

  assign diff     = {req.data.source_y[31], req.data.source_y}
                  - {req.data.ground_y[31], req.data.ground_y};
  assign diff_adj = diff + (diff[32] ? ssp_pkg::FADE_ROUND : 33'sd0);
  assign fq       = diff_adj >>> ssp_pkg::FADE_SHIFT;
  assign fade_neg = (fq < -ssp_pkg::FADE_BIAS);
  assign fade_val = (fq > ssp_pkg::FADE_TOP) ? ssp_pkg::FADE_MAX
                                             : 6'(fq + ssp_pkg::FADE_BIAS);
  assign drop     = fade_neg || (req.data.normal_y >= ssp_pkg::NY_STEEP)
                  || (slots_used >= SW'(MAX_SLOTS));

  // The output register frees up in the same cycle that its word is taken.
  logic out_free;
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

  // A result word is loaded at a clear, at a dropped request and when a
  // queued shadow finishes.
  logic out_load;
  assign out_load = ((state == S_IDLE) && req.valid && req.ready
                     && ((req.data.req_type == ssp_pkg::REQ_CLEAR) || drop))
                  || ((state == S_FIN) && out_free);

  // Shared multiplier: one operand pair per division, then the magnitude of
  // the product goes to the divider and the quotient sign is kept in div_neg.
  logic signed [16:0] ny17;
  logic signed [16:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [32:0] prod;
  logic [ssp_pkg::NUM_W-1:0] prod_mag;
  logic [ssp_pkg::DEN_W-1:0] den;
  logic [16:0]        ny_mag;

  assign ny17   = 17'(item.normal_y);
  assign ny_mag = 17'(17'sd0 - ny17);
  assign mul_b  = $signed({1'b0, size_r});

  always_comb begin
    unique case (step)
      STEP_SCALE: mul_a = ssp_pkg::SCALE_BIAS - ny17;
      STEP_SLOPE: mul_a = 17'(item.normal_z) + 17'(item.normal_x);
      default:    mul_a = 17'(item.normal_z) - 17'(item.normal_x);
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_mag = prod[32] ? ssp_pkg::NUM_W'(-prod) : prod[ssp_pkg::NUM_W-1:0];
  // Normal y is always negative here; the scale divisor is positive.
  assign den      = (step == STEP_SCALE) ? ssp_pkg::SCALE_DIV : ny_mag[15:0];

  logic                      div_start;
  logic                      div_done;
  logic [ssp_pkg::NUM_W-1:0] div_quo;
  logic signed [31:0]        quo_s;

  assign div_start = (state == S_MUL);
  assign quo_s     = div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

  ssp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod_mag),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Result word assembly. The second corner quotient is the exact negation of
  // the first, since truncation toward zero is symmetric.
  logic signed [31:0] qb;
  logic [16:0]        pt;
  logic [13:0]        pt3;
  logic [5:0]         popac;
  ssp_pkg::out_item_t fin_word;

  assign qb  = -qa;
  assign pt  = 17'(ssp_pkg::POPAC_BIAS - ny17);
  assign pt3 = {pt[12:0], 1'b0} + {1'b0, pt[12:0]};
  assign popac = (item.normal_y < ssp_pkg::NY_FLAT) ? ssp_pkg::POPAC_FLAT : pt3[13:8];

  always_comb begin
    fin_word                    = '0;
    fin_word.accepted           = 1'b1;
    fin_word.slot               = 6'(slots_used);
    fin_word.fade_opacity       = fade;
    fin_word.out_pos_x          = item.pos_x;
    fin_word.out_pos_y          = item.ground_y + (slope <<< 5);
    fin_word.out_pos_z          = item.pos_z;
    fin_word.out_size           = 16'sd0 - $signed({1'b0, size_r});
    fin_word.corner_offset_a    = qa[15:0] - slope[15:0];
    fin_word.corner_offset_b    = qb[15:0] - slope[15:0];
    fin_word.corner_offset_c    = 16'sd0 - {slope[14:0], 1'b0};
    fin_word.projection_opacity = popac;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= STEP_SCALE;
      slots_used <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            item   <= req.data;
            fade   <= fade_val;
            size_r <= req.data.shadow_size;
            if (req.data.req_type == ssp_pkg::REQ_CLEAR) begin
              slots_used <= '0;
              out_word   <= '0;
            end else if (drop) begin
              out_word   <= '0;
            end else begin
              // Only steeper ground (normal y above NY_SCALE) needs the size scaling division.
              step  <= (req.data.normal_y > ssp_pkg::NY_SCALE) ? STEP_SCALE : STEP_SLOPE;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          div_neg <= prod[32] ^ (step != STEP_SCALE);
          state   <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            case (step)
              STEP_SCALE: begin
                size_r <= quo_s[14:0];
                step   <= STEP_SLOPE;
                state  <= S_MUL;
              end
              STEP_SLOPE: begin
                slope <= quo_s;
                step  <= STEP_QA;
                state <= S_MUL;
              end
              default: begin
                qa    <= quo_s;
                state <= S_FIN;
              end
            endcase
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_word   <= fin_word;
            slots_used <= slots_used + SW'(1);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_slots_bounded: assert property (@(posedge clk) disable iff (rst)
      slots_used <= SW'(MAX_SLOTS))
    else $error("slot count beyond the slot limit");
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
      req.ready |-> (state == S_IDLE))
    else $error("request taken while a shadow is in progress");
  a_opacity_range: assert property (@(posedge clk) disable iff (rst)
      rsp.valid |-> (rsp.data.fade_opacity <= ssp_pkg::FADE_MAX
                     && rsp.data.projection_opacity <= ssp_pkg::POPAC_FLAT))
    else $error("opacity out of range");
  a_slot_count_step: assert property (@(posedge clk) disable iff (rst)
      (state == S_FIN && out_free) |=> (slots_used == $past(slots_used) + SW'(1)))
    else $error("slot count did not advance on a filled slot");

endmodule

FILE: sv/ssp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_div: radix-2 restoring divider
// Unsigned division, one quotient bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module ssp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ssp_pkg::NUM_W-1:0]   num,
  input  logic [ssp_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [ssp_pkg::NUM_W-1:0]   quo
);

  localparam int CW = $clog2(ssp_pkg::NUM_W);

  logic                      busy;
  logic [CW-1:0]             cnt;
  logic [ssp_pkg::DEN_W-1:0] rem;
  logic [ssp_pkg::DEN_W-1:0] dvs;
  logic [ssp_pkg::DEN_W:0]   shifted;
  logic [ssp_pkg::DEN_W+1:0] trial;

  assign shifted = {rem, quo[ssp_pkg::NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvs  <= den;
        quo  <= num;
      end else if (busy) begin
        // The remainder stays below the divisor, so it fits DEN_W bits.
        if (!trial[ssp_pkg::DEN_W+1]) begin
          rem <= trial[ssp_pkg::DEN_W-1:0];
          quo <= {quo[ssp_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem <= shifted[ssp_pkg::DEN_W-1:0];
          quo <= {quo[ssp_pkg::NUM_W-2:0], 1'b0};
        end
        cnt <= cnt + CW'(1);
        if (cnt == CW'(ssp_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a running division");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held for more than one cycle");

endmodule
